// ----- hw/rtl/lph_pkg.sv -----
// Shared types, codes and widths of the linear probing hash table.
package lph_pkg;

	localparam int HASH_W      = 31;
	localparam int KEY_W       = 32;
	localparam int VALUE_W     = 32;
	localparam int COUNT_OUT_W = 9;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_GET = 1'b1;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_BAD_HASH,
		ST_NOT_FOUND
	} lph_status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_START,
		BK_EVAL,
		BK_DONE
	} lph_back_state_t;

	// One classified request as it travels from front to back.
	typedef struct packed {
		logic               cmd;
		logic               neg;
		logic [HASH_W-1:0]  hash;
		logic [VALUE_W-1:0] value;
	} lph_item_t;

endpackage

// ----- hw/rtl/linear_probe_hash_table.sv -----
// Top level of the linear probing hash table: front end, queue and probe engine.
//
//   channel   direction  handshake          payload
//   request   in         push / full        cmd, key_hash, store_value
//   result    out        empty / pop        status, read_value, entry_count
//
// A request is taken when push is high and full is low; a result is taken when
// pop is high and empty is low, and exactly one result follows each request.
// With a power-of-two TABLE_SIZE an item passes through the probe engine's start
// state, an evaluation per slot walked (one memory read per slot) and the done
// state, so a hit or a free home slot ends the walk there. For any other TABLE_SIZE
// the front end adds a reciprocal multiply, a subtract and the hand-off to the
// queue, takes a new item only after handing the last one to the queue, and
// overlaps the probe of the item ahead.
// After reset the engine clears the valid bits, one slot per cycle, through every
// slot; full stays high during that pass.
// The two-entry queue lets requests be taken while a result waits for pop, and
// the engine stalls only when its finished result cannot move into the output
// register.
module linear_probe_hash_table #(
	parameter int TABLE_SIZE = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  cmd,
	input  logic signed [lph_pkg::KEY_W-1:0]      key_hash,
	input  logic [lph_pkg::VALUE_W-1:0]           store_value,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [1:0]                            status,
	output logic [lph_pkg::VALUE_W-1:0]           read_value,
	output logic [lph_pkg::COUNT_OUT_W-1:0]       entry_count
);
	import lph_pkg::*;

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int QW = $bits(lph_item_t) + IW;

	// Front end to queue.
	logic            fq_push;
	logic            fq_full;
	lph_item_t       fq_item;
	logic [IW-1:0]   fq_idx;

	// Queue to probe engine.
	logic            bq_valid;
	logic            bq_pop;
	logic [QW-1:0]   bq_data;
	lph_item_t       bq_item;
	logic [IW-1:0]   bq_idx;

	// High while the engine clears its valid bits after reset.
	logic            clearing;

	lph_front #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.key_hash    (key_hash),
		.store_value (store_value),
		.hold        (clearing),
		.q_full      (fq_full),
		.q_push      (fq_push),
		.q_item      (fq_item),
		.q_idx       (fq_idx)
	);

	lph_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (fq_push),
		.wr_data   ({fq_item, fq_idx}),
		.full      (fq_full),
		.rd_en     (bq_pop),
		.rd_data   (bq_data),
		.not_empty (bq_valid)
	);

	// The queue word carries the classified item above its home slot index.
	assign bq_item = bq_data[QW-1:IW];
	assign bq_idx  = bq_data[IW-1:0];

	lph_back #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (bq_valid),
		.q_item      (bq_item),
		.q_idx       (bq_idx),
		.q_pop       (bq_pop),
		.clearing    (clearing),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

endmodule

// ----- hw/rtl/lph_front.sv -----
// Front end: accepts requests, splits off the sign and finds the home slot.
module lph_front #(
	parameter int TABLE_SIZE = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd,
	input  logic signed [lph_pkg::KEY_W-1:0]  key_hash,
	input  logic [lph_pkg::VALUE_W-1:0]       store_value,
	input  logic                              hold,
	input  logic                              q_full,
	output logic                              q_push,
	output lph_pkg::lph_item_t                q_item,
	output logic [$clog2(TABLE_SIZE)-1:0]     q_idx
);
	import lph_pkg::*;

	localparam int  IW   = $clog2(TABLE_SIZE);
	localparam bit  POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

	lph_item_t in_item;

	always_comb begin
		in_item.cmd   = cmd;
		in_item.neg   = key_hash[KEY_W-1];
		in_item.hash  = key_hash[HASH_W-1:0];
		in_item.value = store_value;
	end

	generate
		if (POW2) begin : g_mask
			// The home slot is simply the low bits of the hash.
			assign full   = q_full | hold;
			assign q_push = push & ~full;
			assign q_item = in_item;
			assign q_idx  = key_hash[IW-1:0];
		end else begin : g_mod
			localparam int SH  = HASH_W + IW;
			localparam int PW  = HASH_W + 32;
			localparam int QTW = PW - SH;
			localparam logic [31:0] RECIP =
				32'(((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
			localparam logic [1:0] STEP_MUL  = 2'd0;
			localparam logic [1:0] STEP_SUB  = 2'd1;
			localparam logic [1:0] STEP_DONE = 2'd2;

			logic              busy_q;
			logic [1:0]        step_q;
			logic [HASH_W-1:0] h_q;
			logic [PW-1:0]     prod_q;
			logic [IW-1:0]     rem_q;
			lph_item_t         item_q;
			logic [QTW-1:0]    quo;
			logic [HASH_W-1:0] quo_t;
			logic [HASH_W-1:0] rem_full;
			logic              accept;
			logic              done;

			// The remainder is the hash minus quotient times size. The quotient comes from
			// a multiply by the rounded-up reciprocal, which is exact for every 31-bit hash.
			assign quo      = prod_q[PW-1:SH];
			assign quo_t    = HASH_W'(quo) * HASH_W'(TABLE_SIZE);
			assign rem_full = h_q - quo_t;
			assign done     = busy_q && (step_q == STEP_DONE);
			assign full     = busy_q | hold;
			assign accept   = push & ~full;
			assign q_push   = done & ~q_full;
			assign q_item   = item_q;
			assign q_idx    = rem_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					step_q <= STEP_MUL;
				end else if (accept) begin
					busy_q <= 1'b1;
					step_q <= STEP_MUL;
				end else if (busy_q && step_q != STEP_DONE) begin
					step_q <= step_q + 1'b1;
				end else if (q_push) begin
					busy_q <= 1'b0;
				end
			end

			always_ff @(posedge clk) begin
				if (accept) begin
					item_q <= in_item;
					h_q    <= key_hash[HASH_W-1:0];
				end
				if (busy_q && step_q == STEP_MUL) begin
					prod_q <= PW'(h_q) * PW'(RECIP);
				end
				if (busy_q && step_q == STEP_SUB) begin
					rem_q <= rem_full[IW-1:0];
				end
			end
		end
	endgenerate

endmodule

// ----- hw/rtl/lph_queue.sv -----
// Short queue that decouples the front end from the probe engine.
module lph_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             not_empty
);
	import lph_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [FW-1:0]    fill_q;
	logic             do_wr;
	logic             do_rd;

	assign full      = (fill_q == FW'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign do_wr     = wr_en & ~full;
	assign do_rd     = rd_en & not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- hw/rtl/lph_back.sv -----
// Probe engine: slot memories, linear probe walk, entry count and result register.
module lph_back #(
	parameter int TABLE_SIZE = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	input  lph_pkg::lph_item_t                    q_item,
	input  logic [$clog2(TABLE_SIZE)-1:0]         q_idx,
	output logic                                  q_pop,
	output logic                                  clearing,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [1:0]                            status,
	output logic [lph_pkg::VALUE_W-1:0]           read_value,
	output logic [lph_pkg::COUNT_OUT_W-1:0]       entry_count
);
	import lph_pkg::*;

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);

	lph_back_state_t state_q, state_d;

	logic                valid_mem [TABLE_SIZE];
	logic [HASH_W-1:0]   hash_mem  [TABLE_SIZE];
	logic [VALUE_W-1:0]  value_mem [TABLE_SIZE];

	logic                rd_valid_s1;
	logic [HASH_W-1:0]   rd_hash_s1;
	logic [VALUE_W-1:0]  rd_value_s1;

	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       n_q;
	logic [CW-1:0]       count_q;
	logic                cmd_q;
	logic [HASH_W-1:0]   hash_q;
	logic [VALUE_W-1:0]  val_q;
	lph_status_t         res_status_q;
	logic [VALUE_W-1:0]  res_value_q;

	logic                out_valid_q;
	lph_status_t         out_status_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	logic [IW-1:0]       idx_next;
	logic [IW-1:0]       rd_addr;
	logic                table_full;
	logic                early_stop;
	logic                slot_free;
	logic                hit;
	logic                stop;
	logic                last;
	logic                out_free;
	logic                valid_we;
	logic                valid_wd;
	logic                slot_we;
	logic                load_out;

	assign idx_next   = (idx_q == IW'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
	assign table_full = (count_q >= CW'(TABLE_SIZE));
	assign early_stop = (q_item.cmd == CMD_PUT && table_full) || q_item.neg;
	assign slot_free  = ~rd_valid_s1;
	assign hit        = rd_valid_s1 && (rd_hash_s1 == hash_q);
	assign stop       = slot_free | hit;
	assign last       = (n_q == IW'(TABLE_SIZE - 1));
	assign out_free   = ~out_valid_q | pop;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (idx_q == IW'(TABLE_SIZE - 1)) begin
					state_d = BK_START;
				end
			end
			BK_START: begin
				if (q_valid) begin
					state_d = early_stop ? BK_DONE : BK_EVAL;
				end
			end
			BK_EVAL: begin
				if (stop || last) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_START;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		clearing = 1'b0;
		rd_addr  = q_idx;
		valid_we = 1'b0;
		valid_wd = 1'b1;
		slot_we  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				clearing = 1'b1;
				valid_we = 1'b1;
				valid_wd = 1'b0;
			end
			BK_START: begin
				q_pop = q_valid;
			end
			BK_EVAL: begin
				rd_addr  = idx_next;
				slot_we  = (cmd_q == CMD_PUT) && stop;
				valid_we = (cmd_q == CMD_PUT) && slot_free;
			end
			BK_DONE: begin
				load_out = out_free;
			end
			default: begin
				clearing = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_we) begin
			valid_mem[idx_q] <= valid_wd;
		end
		if (slot_we) begin
			hash_mem[idx_q]  <= hash_q;
			value_mem[idx_q] <= val_q;
		end
		rd_valid_s1 <= valid_mem[rd_addr];
		rd_hash_s1  <= hash_mem[rd_addr];
		rd_value_s1 <= value_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			idx_q       <= '0;
			n_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_CLEAR: idx_q <= idx_next;
				BK_START: begin
					if (q_valid) begin
						idx_q <= q_idx;
						n_q   <= '0;
					end
				end
				BK_EVAL: begin
					if (!stop && !last) begin
						idx_q <= idx_next;
						n_q   <= n_q + 1'b1;
					end
					if (cmd_q == CMD_PUT && slot_free) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q        <= q_item.cmd;
			hash_q       <= q_item.hash;
			val_q        <= q_item.value;
			res_status_q <= (q_item.cmd == CMD_PUT && table_full) ? ST_FULL : ST_BAD_HASH;
			res_value_q  <= '0;
		end else if (state_q == BK_EVAL && (stop || last)) begin
			if (cmd_q == CMD_PUT) begin
				res_status_q <= stop ? ST_OK : ST_FULL;
			end else if (hit) begin
				res_status_q <= ST_OK;
				res_value_q  <= rd_value_s1;
			end else begin
				res_status_q <= ST_NOT_FOUND;
			end
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_count_q  <= COUNT_OUT_W'(count_q);
		end
	end

	assign empty       = ~out_valid_q;
	assign status      = out_status_q;
	assign read_value  = out_value_q;
	assign entry_count = out_count_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_SIZE))
		else $error("entry count exceeds table size");

	a_fill_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EVAL && cmd_q == CMD_PUT && slot_free)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("filled slot not counted");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |-> out_value_q == '0)
		else $error("failed item carries a nonzero value");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DONE && !out_free)
		|=> (state_q == BK_DONE && $stable(res_status_q) && $stable(res_value_q)))
		else $error("pending result lost while output stalled");
`endif

endmodule

// ----- verif/linear_probe_hash_table_tb.sv -----
// Self-checking testbench for the linear probing hash table: shadow table, stimulus and checks.
module linear_probe_hash_table_tb;
	import lph_pkg::*;

	localparam int TABLE_SIZE = 256;
	// Longest quiet stretch that a correct block can show: a full-table probe walks every
	// slot, the queue can hold two items ahead of it, and the receiver may stall on top.
	localparam int QUIET_LIMIT = 4000;
	// Cycles allowed after the last result for anything stray to come out.
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_ITEMS = 500;

	// One expected result item, in the widths of the result ports.
	typedef struct {
		lph_status_t          status;
		logic [VALUE_W-1:0]   value;
		logic [COUNT_OUT_W-1:0] count;
	} lph_result_t;

	// Shadow copy of the table. Every accepted request is applied to it, in order, and
	// the result that the block should give is queued until the block hands it out.
	class hash_table_shadow;
		bit                 slot_used [TABLE_SIZE];
		logic [HASH_W-1:0]  slot_key [TABLE_SIZE];
		logic [VALUE_W-1:0] slot_data [TABLE_SIZE];
		int unsigned        used_count;
		int unsigned        peak_count;
		lph_result_t        awaited_results [$];
		int                 errors;
		int                 status_tally [4];
		int                 put_count;
		int                 get_count;

		// Walks from the home slot, one step at a time with wrap, and stops at a free
		// slot or at the slot that holds this hash. Returns -1 if every slot was visited.
		function int find_slot(logic [HASH_W-1:0] h);
			int unsigned idx;
			idx = h % TABLE_SIZE;
			for (int n = 0; n < TABLE_SIZE; n++) begin
				if (!slot_used[idx] || slot_key[idx] == h)
					return idx;
				idx = (idx + 1) % TABLE_SIZE;
			end
			return -1;
		endfunction

		function void note_request(logic c, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
			lph_result_t r;
			int slot;
			r.status = ST_OK;
			r.value = '0;
			if (c == CMD_PUT) begin
				put_count++;
				// The full check wins over everything, even a put that would only update.
				if (used_count >= TABLE_SIZE) begin
					r.status = ST_FULL;
				end else if (k[KEY_W-1]) begin
					r.status = ST_BAD_HASH;
				end else begin
					slot = find_slot(k[HASH_W-1:0]);
					if (slot < 0) begin
						r.status = ST_FULL;
					end else begin
						if (!slot_used[slot]) begin
							slot_used[slot] = 1'b1;
							slot_key[slot] = k[HASH_W-1:0];
							used_count++;
						end
						slot_data[slot] = v;
					end
				end
			end else begin
				get_count++;
				if (k[KEY_W-1]) begin
					r.status = ST_BAD_HASH;
				end else begin
					slot = find_slot(k[HASH_W-1:0]);
					if (slot >= 0 && slot_used[slot])
						r.value = slot_data[slot];
					else
						r.status = ST_NOT_FOUND;
				end
			end
			if (used_count > peak_count)
				peak_count = used_count;
			r.count = used_count[COUNT_OUT_W-1:0];
			status_tally[int'(r.status)]++;
			awaited_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [VALUE_W-1:0] rv,
				logic [COUNT_OUT_W-1:0] cnt);
			lph_result_t e;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d value %h count %0d",
					$time, st, rv, cnt);
				errors++;
				return;
			end
			e = awaited_results.pop_front();
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (rv !== e.value) begin
				$display("%0t: read_value expected %h actual %h", $time, e.value, rv);
				errors++;
			end
			if (cnt !== e.count) begin
				$display("%0t: entry_count expected %0d actual %0d", $time, e.count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      push = 1'b0;
	logic                      full;
	logic                      cmd = CMD_PUT;
	logic signed [KEY_W-1:0]   key_hash = '0;
	logic [VALUE_W-1:0]        store_value = '0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic [1:0]                status;
	logic [VALUE_W-1:0]        read_value;
	logic [COUNT_OUT_W-1:0]    entry_count;

	hash_table_shadow shadow = new();

	// Idle rates in percent of cycles, changed from phase to phase.
	int send_idle_pct = 7;
	int recv_idle_pct = 68;
	int quiet_cycles = 0;

	// Non-negative hashes that were put or sent as directed items, so that gets and updates can find them again.
	logic [KEY_W-1:0] known_keys [$];

	linear_probe_hash_table #(
		.TABLE_SIZE(TABLE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.key_hash(key_hash),
		.store_value(store_value),
		.empty(empty),
		.pop(pop),
		.status(status),
		.read_value(read_value),
		.entry_count(entry_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver decides on every falling edge whether it wants a result item; the
	// item is taken and checked at the rising edge where pop meets a non-empty queue.
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			shadow.check_result(status, read_value, entry_count);
	end

	// The watchdog counts cycles in which neither side moves an item. The reset clearing
	// pass and the longest probe both fit well inside the limit.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("linear_probe_hash_table_tb: errors");
				$finish;
			end
		end
	end

	// Offers one request item. Push is left high after acceptance so that back-to-back
	// items need no gap; a random idle stretch lowers it first. Each falling edge sees
	// only one assignment to push.
	task automatic send_item(input logic c, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		cmd <= c;
		key_hash <= k;
		store_value <= v;
		do
			@(posedge clk);
		while (full !== 1'b0);
		shadow.note_request(c, k, v);
	endtask

	// Sends a directed item and remembers a non-negative hash for the random part.
	task automatic directed_item(input logic c, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		send_item(c, k, v);
		if (!k[KEY_W-1])
			known_keys.push_back(k);
	endtask

	// Most fresh hashes land on a narrow band of home slots that straddles the wrap
	// point, so clusters build up, probes run long and walk from the last slot to slot 0.
	function automatic logic [KEY_W-1:0] fresh_hash();
		int unsigned home;
		int unsigned upper;
		if ($urandom_range(99) < 30)
			return {1'b0, HASH_W'($urandom_range(32'h7FFF_FFFF, 0))};
		home = ($urandom_range(23) + TABLE_SIZE - 12) % TABLE_SIZE;
		upper = $urandom_range(32'h7FFF_FFFF / TABLE_SIZE - 1, 0);
		return upper * TABLE_SIZE + home;
	endfunction

	// One random request item. fresh_pct sets how often a new hash is put, which sets
	// how fast the table fills over a phase.
	task automatic random_item(input int fresh_pct);
		int roll;
		logic [KEY_W-1:0] k;
		logic c;
		roll = $urandom_range(99);
		if (roll < 5) begin
			// A negative hash, as a put or a get.
			k = $urandom | 32'h8000_0000;
			c = 1'($urandom_range(1));
		end else if (roll < 5 + fresh_pct) begin
			k = fresh_hash();
			known_keys.push_back(k);
			c = CMD_PUT;
		end else if (roll < 15 + fresh_pct) begin
			// A put of a remembered hash, usually an update of one in the table; refused once the table is full.
			k = (known_keys.size() != 0) ? known_keys[$urandom_range(known_keys.size() - 1)]
				: fresh_hash();
			c = CMD_PUT;
		end else if (roll < 30 + fresh_pct) begin
			// Most likely a miss; on a full table it visits every slot.
			k = fresh_hash();
			c = CMD_GET;
		end else begin
			k = (known_keys.size() != 0) ? known_keys[$urandom_range(known_keys.size() - 1)]
				: fresh_hash();
			c = CMD_GET;
		end
		send_item(c, k, $urandom);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: the empty table, extreme hashes and values, an update, a
		// collision chain that wraps from the last slot to slot 0, a miss at the end of
		// that chain, and negative hashes on both commands.
		directed_item(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		directed_item(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		directed_item(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		directed_item(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
		directed_item(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		directed_item(CMD_PUT, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
		directed_item(CMD_PUT, 32'h0000_00FF, 32'h5A5A_5A5A);
		directed_item(CMD_PUT, 32'h0000_01FF, 32'h0123_4567);
		directed_item(CMD_GET, 32'h0000_00FF, 32'h0000_0000);
		directed_item(CMD_GET, 32'h0000_01FF, 32'hFFFF_FFFF);
		directed_item(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		directed_item(CMD_GET, 32'h0000_02FF, 32'h0000_0000);
		directed_item(CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
		directed_item(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		directed_item(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		directed_item(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0001);
		directed_item(CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
		directed_item(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		directed_item(CMD_PUT, 32'h0000_0100, 32'h8000_0000);
		directed_item(CMD_GET, 32'h0000_0100, 32'h0000_0000);
		directed_item(CMD_GET, 32'h0000_0200, 32'h0000_0000);

		// Random part in three phases. The table fills over the first two; the third
		// runs on a full table, where every put is refused, a negative put reports full,
		// and a get of a missing hash walks all slots before reporting not found.
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_item(25);
		send_idle_pct = 68;
		recv_idle_pct = 7;
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_item(60);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_item(20);

		@(negedge clk);
		push <= 1'b0;
		while (shadow.awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d puts and %0d gets: %0d ok, %0d refused full, %0d bad hash,",
			shadow.put_count, shadow.get_count, shadow.status_tally[ST_OK],
			shadow.status_tally[ST_FULL], shadow.status_tally[ST_BAD_HASH]);
		$display("%0d not found; the table held up to %0d of %0d slots",
			shadow.status_tally[ST_NOT_FOUND], shadow.peak_count, TABLE_SIZE);
		if (shadow.errors == 0 && shadow.awaited_results.size() == 0) begin
			$display("linear_probe_hash_table_tb: clean");
		end else begin
			$display("linear_probe_hash_table_tb: errors");
		end
		$finish;
	end

endmodule
